// ----- src/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helper functions of the UTF-8 to UTF-16
// transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_REPLACEMENT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CP      = 1'd1;
  localparam int unsigned CfgDataW = 21;

  localparam logic [15:0] REPL_RESET   = 16'h003F;
  localparam logic [20:0] MAX_CP_RESET = 21'h10FFFF;

  localparam logic [30:0] SURR_FIRST = 31'h0000D800;
  localparam logic [30:0] SURR_LAST  = 31'h0000DFFF;
  localparam logic [30:0] BMP_LAST   = 31'h0000FFFF;
  localparam logic [30:0] SUPP_BASE  = 31'h00010000;
  localparam logic [15:0] HIGH_BASE  = 16'hD800;
  localparam logic [5:0]  LOW_PREFIX = 6'b110111;

  // output queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [15:0] unit;
    logic        error;
    logic        last;
  } unit_t;

  // zero, one or two units produced by one byte
  typedef struct packed {
    logic [1:0] num;
    unit_t      u0;
    unit_t      u1;
  } dec_res_t;

  // sequence length from the lead byte (up to six), zero for a stray continuation byte or 0xFE/0xFF
  function automatic logic [2:0] lead_length(logic [7:0] b);
    logic [2:0] n;
    case (b) inside
      [8'h00:8'h7F]: n = 3'd1;
      [8'h80:8'hBF]: n = 3'd0;
      [8'hC0:8'hDF]: n = 3'd2;
      [8'hE0:8'hEF]: n = 3'd3;
      [8'hF0:8'hF7]: n = 3'd4;
      [8'hF8:8'hFB]: n = 3'd5;
      [8'hFC:8'hFD]: n = 3'd6;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic dec_res_t repl_result(logic [15:0] repl);
    dec_res_t r;
    r.num = 2'd1;
    r.u0  = '{unit: repl, error: 1'b1, last: 1'b1};
    r.u1  = '0;
    return r;
  endfunction

  // finished code point: replacement, one plain unit or a surrogate pair
  function automatic dec_res_t finish_code(logic [30:0] cp, logic bad,
                                           logic [15:0] repl, logic [20:0] max_cp);
    dec_res_t    r;
    logic [30:0] v;
    v = cp - SUPP_BASE;
    r = '0;
    if (bad || (cp > {10'd0, max_cp}) || ((cp >= SURR_FIRST) && (cp <= SURR_LAST))) begin
      r = repl_result(repl);
    end else if (cp <= BMP_LAST) begin
      r.num = 2'd1;
      r.u0  = '{unit: cp[15:0], error: 1'b0, last: 1'b1};
    end else begin
      r.num = 2'd2;
      r.u0  = '{unit: v[25:10] + HIGH_BASE, error: 1'b0, last: 1'b0};
      r.u1  = '{unit: {LOW_PREFIX, v[9:0]}, error: 1'b0, last: 1'b1};
    end
    return r;
  endfunction

endpackage

// ----- src/u8u16_in_if.sv -----
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte input channel: valid/ready handshake with one UTF-8 byte.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- src/u8u16_out_if.sv -----
// ----------------------------------------------------------------------------
// u8u16_out_if
// Unit output channel: valid/ready handshake with one UTF-16 code unit.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        out_error;
  logic        out_last;

  modport source (output valid, output out_unit, output out_error, output out_last,
                  input ready);
  modport sink   (input valid, input out_unit, input out_error, input out_last,
                  output ready);
endinterface

// ----- src/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and per-byte decode: gathers continuation bytes and
// produces zero, one or two UTF-16 units for each byte.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic [15:0]          repl_i,
  input  logic [20:0]          max_cp_i,
  output u8u16_pkg::dec_res_t  res_o,
  output logic [2:0]           pending_o
);

  logic [2:0]  pending_q, pending_d;
  logic [30:0] accum_q, accum_d;
  logic        bad_q, bad_d;

  logic [2:0]  lead_n;
  logic [7:0]  lead_mask;
  logic [2:0]  pend_dec;
  logic [30:0] accum_shift;
  logic        bad_cont;

  assign lead_n      = u8u16_pkg::lead_length(in_byte_i);
  assign lead_mask   = 8'h7F >> lead_n;
  assign pend_dec    = pending_q - 3'd1;
  assign accum_shift = {accum_q[24:0], in_byte_i[5:0]};
  assign bad_cont    = bad_q | (in_byte_i[7:6] != 2'b10);

  always_comb begin
    res_o     = '0;
    pending_d = pending_q;
    accum_d   = accum_q;
    bad_d     = bad_q;
    if (pending_q == 3'd0) begin
      if (lead_n == 3'd0) begin
        res_o = u8u16_pkg::repl_result(repl_i);
      end else if (lead_n == 3'd1) begin
        res_o = u8u16_pkg::finish_code({23'd0, in_byte_i}, 1'b0, repl_i, max_cp_i);
      end else if (in_last_i) begin
        // string ends right after a multi-byte lead
        res_o = u8u16_pkg::repl_result(repl_i);
      end else begin
        pending_d = lead_n - 3'd1;
        accum_d   = {23'd0, in_byte_i & lead_mask};
        bad_d     = 1'b0;
      end
    end else begin
      if (pend_dec == 3'd0) begin
        res_o     = u8u16_pkg::finish_code(accum_shift, bad_cont, repl_i, max_cp_i);
        pending_d = 3'd0;
        accum_d   = '0;
        bad_d     = 1'b0;
      end else if (in_last_i) begin
        res_o     = u8u16_pkg::repl_result(repl_i);
        pending_d = 3'd0;
        accum_d   = '0;
        bad_d     = 1'b0;
      end else begin
        pending_d = pend_dec;
        accum_d   = accum_shift;
        bad_d     = bad_cont;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
      accum_q   <= '0;
      bad_q     <= 1'b0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      accum_q   <= accum_d;
      bad_q     <= bad_d;
    end
  end

  assign pending_o = pending_q;

endmodule

// ----- src/u8u16_fifo.sv -----
// ----------------------------------------------------------------------------
// u8u16_fifo
// Small output queue of UTF-16 units: takes up to two units a cycle,
// gives one a cycle.
// ----------------------------------------------------------------------------
module u8u16_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_num_i,
  input  u8u16_pkg::unit_t                  push0_i,
  input  u8u16_pkg::unit_t                  push1_i,
  input  logic                              pop_i,
  output u8u16_pkg::unit_t                  head_o,
  output logic [u8u16_pkg::FifoCw-1:0]      count_o
);

  u8u16_pkg::unit_t mem_q [u8u16_pkg::FifoDepth];

  logic [u8u16_pkg::FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [u8u16_pkg::FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [u8u16_pkg::FifoCw-1:0] cnt_q, cnt_d;
  logic [u8u16_pkg::FifoAw-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign wr_ptr_d  = wr_ptr_q + push_num_i[u8u16_pkg::FifoAw-1:0];
  assign rd_ptr_d  = rd_ptr_q + {{(u8u16_pkg::FifoAw-1){1'b0}}, pop_i};
  assign cnt_d     = cnt_q + u8u16_pkg::FifoCw'(push_num_i)
                     - {{(u8u16_pkg::FifoCw-1){1'b0}}, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// ----- src/utf8_to_utf16_transcoder.sv -----
// A byte accepted is held in the input register until the queue has room for
//   a surrogate pair; its units are then written into the output queue.
// Throughput: one byte per cycle while the queue has room, limited by the
//   one-unit-per-cycle output queue port (a surrogate pair leaves as two units).
// Reset: asynchronous, active low; clears the sequence state, the queue and
//   loads replacement '?' and limit 0x10FFFF.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streams UTF-8 bytes in and UTF-16 units out, with replacement units for
// malformed or out-of-range sequences.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  u8u16_in_if.sink                          byte_in,
  u8u16_out_if.source                       unit_out,
  input  logic                              cfg_we_i,
  input  logic [u8u16_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [u8u16_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic [15:0] repl_q;
  logic [20:0] max_cp_q;

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  logic        in_fire;
  logic        proc;
  logic        pop;

  u8u16_pkg::dec_res_t              res;
  u8u16_pkg::unit_t                 head;
  logic [u8u16_pkg::FifoCw-1:0]     count;
  logic [2:0]                       pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q   <= u8u16_pkg::REPL_RESET;
      max_cp_q <= u8u16_pkg::MAX_CP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        u8u16_pkg::CFG_REPLACEMENT: repl_q   <= cfg_wdata_i[15:0];
        u8u16_pkg::CFG_MAX_CP:      max_cp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decode only when the queue can absorb a surrogate pair
  assign proc          = in_v_q && (count <= u8u16_pkg::FifoCw'(u8u16_pkg::FifoDepth - 2));
  assign byte_in.ready = !in_v_q || proc;
  assign in_fire       = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_fire) begin
      in_v_q <= 1'b1;
    end else if (proc) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= byte_in.in_byte;
      in_last_q <= byte_in.in_last;
    end
  end

  u8u16_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (proc),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .repl_i    (repl_q),
    .max_cp_i  (max_cp_q),
    .res_o     (res),
    .pending_o (pending)
  );

  assign pop = unit_out.valid && unit_out.ready;

  u8u16_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (proc ? res.num : 2'd0),
    .push0_i    (res.u0),
    .push1_i    (res.u1),
    .pop_i      (pop),
    .head_o     (head),
    .count_o    (count)
  );

  assign unit_out.valid     = (count != '0);
  assign unit_out.out_unit  = head.unit;
  assign unit_out.out_error = head.error;
  assign unit_out.out_last  = head.last;

  // queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= u8u16_pkg::FifoCw'(u8u16_pkg::FifoDepth))
    else $error("output queue overflow");

  // a held byte that cannot be decoded blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !proc) |-> !byte_in.ready)
    else $error("input accepted while decode stalled");

  // the high half of a pair is always queued together with its low half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unit_out.valid && !unit_out.out_last) |-> (count >= u8u16_pkg::FifoCw'(2)))
    else $error("surrogate pair split in queue");

  // a continuation run never exceeds five bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= 3'd5)
    else $error("sequence length out of range");

endmodule
